@@ design/cfp_pkg.sv @@
// Shared types and constants of the command frame parser.
package cfp_pkg;

  // Action codes carried in the input tuser field.
  localparam logic [1:0] ACT_BYTE   = 2'd0;
  localparam logic [1:0] ACT_RX_ERR = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FIRST_HDR  = 2'd0;
  localparam logic [1:0] CFG_SECOND_HDR = 2'd1;
  localparam logic [1:0] CFG_SET_CODE   = 2'd2;
  localparam logic [1:0] CFG_STOP_CODE  = 2'd3;

  // Frame status codes reported with every result.
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_SET      = 3'd1;
  localparam logic [2:0] ST_STOPPED  = 3'd2;
  localparam logic [2:0] ST_IGNORED  = 3'd3;
  localparam logic [2:0] ST_BAD_SUM  = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;

  // Payload store and target layout.
  localparam int StoreDepth  = 8;
  localparam int StoreIdxW   = 3;
  localparam int TargetLen   = 8;
  localparam int PayloadW    = StoreDepth * 8;
  localparam int TargetW     = 16;
  localparam int TargetSlots = 4;

  // Header and command codes from the configuration registers.
  typedef struct packed {
    logic [7:0] first_hdr;
    logic [7:0] second_hdr;
    logic [7:0] set_code;
    logic [7:0] stop_code;
  } cfp_cfg_t;

  // Outcome of one byte as seen by the target registers.
  typedef struct packed {
    logic       load_targets;
    logic       clear_targets;
    logic [2:0] status;
  } cfp_event_t;

endpackage

@@ design/cfp_hunt.sv @@
// Frame hunt state machine, running checksum and payload store.
module cfp_hunt import cfp_pkg::*; #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                rx_error,
  input  logic [7:0]          rx_byte,
  input  cfp_cfg_t            cfg,
  output cfp_event_t          ev,
  output logic [PayloadW-1:0] payload
);

  localparam int LenW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    HS_HDR1,
    HS_HDR2,
    HS_TYPE,
    HS_LEN,
    HS_PAY,
    HS_CHK
  } hunt_state_t;

  hunt_state_t     state, state_next;
  logic [7:0]      frame_type, frame_type_next;
  logic [LenW-1:0] frame_length, frame_length_next;
  logic [LenW-1:0] payload_count, payload_count_next;
  logic [7:0]      running_xor, running_xor_next;
  logic [LenW:0]   count_inc;
  logic            store_wr;
  logic [7:0]      payload_bytes [StoreDepth];

  assign count_inc = {1'b0, payload_count} + (LenW + 1)'(1);

  // Next-state logic: one transition per received byte.
  always_comb begin
    state_next         = state;
    frame_type_next    = frame_type;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    running_xor_next   = running_xor;
    store_wr           = 1'b0;
    ev                 = '{load_targets: 1'b0, clear_targets: 1'b0, status: ST_NONE};
    if (rx_error) begin
      state_next = HS_HDR1;
    end else if (take) begin
      unique case (state)
        HS_HDR1: begin
          if (rx_byte == cfg.first_hdr) state_next = HS_HDR2;
        end
        HS_HDR2: begin
          state_next = (rx_byte == cfg.second_hdr) ? HS_TYPE : HS_HDR1;
        end
        HS_TYPE: begin
          frame_type_next  = rx_byte;
          running_xor_next = rx_byte;
          state_next       = HS_LEN;
        end
        HS_LEN: begin
          frame_length_next  = LenW'(rx_byte);
          running_xor_next   = running_xor ^ rx_byte;
          payload_count_next = '0;
          if (rx_byte > 8'(MAX_PAYLOAD)) begin
            state_next = HS_HDR1;
            ev.status  = ST_TOO_LONG;
          end else if (rx_byte == 8'd0) begin
            state_next = HS_CHK;
          end else begin
            state_next = HS_PAY;
          end
        end
        HS_PAY: begin
          // Only the first bytes are kept; all of them enter the checksum.
          store_wr           = (payload_count < LenW'(StoreDepth));
          payload_count_next = count_inc[LenW-1:0];
          running_xor_next   = running_xor ^ rx_byte;
          if (count_inc >= {1'b0, frame_length}) state_next = HS_CHK;
        end
        HS_CHK: begin
          state_next = HS_HDR1;
          if (rx_byte != running_xor) begin
            ev.status = ST_BAD_SUM;
          end else if (frame_type == cfg.set_code &&
                       frame_length == LenW'(TargetLen)) begin
            ev.load_targets = 1'b1;
            ev.status       = ST_SET;
          end else if (frame_type == cfg.stop_code && frame_length == '0) begin
            ev.clear_targets = 1'b1;
            ev.status        = ST_STOPPED;
          end else begin
            ev.status = ST_IGNORED;
          end
        end
        default: begin
          state_next = HS_HDR1;
        end
      endcase
    end
  end

  // Hunt state and frame bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= HS_HDR1;
      frame_type    <= '0;
      frame_length  <= '0;
      payload_count <= '0;
      running_xor   <= '0;
    end else begin
      state         <= state_next;
      frame_type    <= frame_type_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
      running_xor   <= running_xor_next;
    end
  end

  // Payload store; only a full-length set-target frame reads it.
  always_ff @(posedge clk) begin
    if (store_wr) payload_bytes[payload_count[StoreIdxW-1:0]] <= rx_byte;
  end

  // Flatten the store, first byte in the lowest bits.
  for (genvar i = 0; i < StoreDepth; i++) begin : g_flat
    assign payload[i*8 +: 8] = payload_bytes[i];
  end

endmodule

@@ design/cfp_targets.sv @@
// Motor target registers and the ready flag.
module cfp_targets import cfp_pkg::*; #(
  parameter int MOTORS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           read_clear,
  input  cfp_event_t                     ev,
  input  logic [PayloadW-1:0]            payload,
  output logic [TargetSlots*TargetW-1:0] targets,
  output logic                           ready_flag
);

  // Ready flag: raised by a decoded command, cleared by a read.
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flag <= 1'b0;
    end else if (step) begin
      if (ev.load_targets || ev.clear_targets) begin
        ready_flag <= 1'b1;
      end else if (read_clear) begin
        ready_flag <= 1'b0;
      end
    end
  end

  // One little-endian 16-bit target per motor; absent motors read as zero.
  for (genvar m = 0; m < TargetSlots; m++) begin : g_motor
    if (m < MOTORS) begin : g_used
      logic [TargetW-1:0] target;
      always_ff @(posedge clk) begin
        if (rst) begin
          target <= '0;
        end else if (step && ev.load_targets) begin
          target <= payload[m*TargetW +: TargetW];
        end else if (step && ev.clear_targets) begin
          target <= '0;
        end
      end
      assign targets[m*TargetW +: TargetW] = target;
    end else begin : g_unused
      assign targets[m*TargetW +: TargetW] = '0;
    end
  end

endmodule

@@ design/command_frame_parser_top.sv @@
// Top level of the command frame parser: beat registers, configuration and glue.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata/s_tuser. tuser holds the
//   action (received byte, receive error, read and clear ready flag) and
//   tdata holds the received byte. Every input beat yields exactly one
//   output beat on m_tvalid/m_tready/m_tdata: the ready flag as it was
//   before the beat, the four motor targets after it and a frame status.
//   Configuration writes (header bytes, command codes) come in on
//   cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high and writes belong in idle periods.
// Timing:
//   An accepted beat is held in the input register, decoded from there and
//   registered into the output register that drives m_tdata.
//   The byte-level state update is one small state transition, so one beat
//   per cycle is sustained while the receiver keeps m_tready high.
// Reset and stalls:
//   Reset returns the hunt to the first header, clears targets and the
//   ready flag and restores the configuration defaults. When the receiver
//   stalls, the result stays in the output register, one more beat waits
//   in the input register and then s_tready drops until the output drains.
module command_frame_parser_top import cfp_pkg::*; #(
  parameter int MAX_PAYLOAD = 32,
  parameter int MOTORS      = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] targets_fresh, [16:1] target_a, [32:17] target_b, [48:33] target_c,
  // [64:49] target_d, [67:65] frame_status, [71:68] zero
  output logic [71:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic                           in_valid;
  logic [1:0]                     in_action;
  logic [7:0]                     in_byte;
  logic                           advance;
  logic                           out_valid;
  logic                           fresh_q;
  logic [2:0]                     status_q;
  logic                           ready_flag;
  logic [TargetSlots*TargetW-1:0] targets;
  logic [PayloadW-1:0]            payload;
  cfp_cfg_t                       cfg;
  cfp_event_t                     ev;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_hdr  <= 8'd170;
      cfg.second_hdr <= 8'd85;
      cfg.set_code   <= 8'd1;
      cfg.stop_code  <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIRST_HDR:  cfg.first_hdr  <= cfg_data;
        CFG_SECOND_HDR: cfg.second_hdr <= cfg_data;
        CFG_SET_CODE:   cfg.set_code   <= cfg_data;
        CFG_STOP_CODE:  cfg.stop_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_byte   <= s_tdata;
    end
  end

  cfp_hunt #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_hunt (
    .clk      (clk),
    .rst      (rst),
    .take     (advance && in_action == ACT_BYTE),
    .rx_error (advance && in_action == ACT_RX_ERR),
    .rx_byte  (in_byte),
    .cfg      (cfg),
    .ev       (ev),
    .payload  (payload)
  );

  cfp_targets #(
    .MOTORS(MOTORS)
  ) u_targets (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .read_clear (in_action == ACT_READ),
    .ev         (ev),
    .payload    (payload),
    .targets    (targets),
    .ready_flag (ready_flag)
  );

  // Output register; the targets themselves are the state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fresh_q  <= ready_flag;
      status_q <= ev.status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, status_q, targets, fresh_q};

  // A decoded command always leaves the ready flag raised.
  a_ready_after_cmd: assert property (@(posedge clk) disable iff (rst)
    advance && (ev.load_targets || ev.clear_targets) |=> ready_flag)
    else $error("ready flag not raised after a decoded command");

  // Load and clear of the targets never coincide.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(ev.load_targets && ev.clear_targets))
    else $error("target load and clear in the same cycle");

  // Only received bytes can report a frame outcome.
  a_status_bytes_only: assert property (@(posedge clk) disable iff (rst)
    advance && in_action != ACT_BYTE |-> ev.status == ST_NONE)
    else $error("frame status on a non-byte beat");

  // A stop command zeroes every target.
  a_stop_zeroes: assert property (@(posedge clk) disable iff (rst)
    advance && ev.clear_targets |=> targets == '0)
    else $error("targets not zero after stop");

endmodule

@@ dv/tb_command_frame_parser_top.sv @@
// Testbench for the command frame parser: directed frames, config sweeps, random traffic, stalls.
`timescale 1ns / 100ps

module tb_command_frame_parser_top;
  import cfp_pkg::*;

  localparam int MaxPayload    = 32;
  localparam int Motors        = 4;
  localparam int RandomItems   = 400;
  localparam int HoldOffCycles = 300;
  localparam int CycleLimit    = 500000;

  // Action code that the block does not define; it must leave everything alone.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam cfp_cfg_t DefaultCfg = '{8'hAA, 8'h55, 8'h01, 8'h02};

  typedef logic [7:0] byte_q_t[$];

  // Hunt states of the frame search.
  typedef enum logic [2:0] {
    HUNT_HDR1, HUNT_HDR2, HUNT_TYPE, HUNT_LEN, HUNT_PAY, HUNT_CHK
  } hunt_e;

  // One output beat, laid out exactly as m_tdata.
  typedef struct packed {
    logic [3:0]         pad;
    logic [2:0]         status;
    logic signed [15:0] tgt_d;
    logic signed [15:0] tgt_c;
    logic signed [15:0] tgt_b;
    logic signed [15:0] tgt_a;
    logic               fresh;
  } parse_out_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [1:0]  s_tuser = ACT_BYTE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_FIRST_HDR;
  logic [7:0]  cfg_data = 8'h00;

  // Shadow copy of the parser state and configuration.
  cfp_cfg_t           cfg_model;
  hunt_e              hunt_st;
  logic [7:0]         frame_kind;
  logic [7:0]         frame_len;
  int                 pay_count;
  logic [7:0]         run_xor;
  logic [7:0]         pay_store [StoreDepth];
  logic signed [15:0] motor_tgt [TargetSlots];
  logic               fresh_flag;

  parse_out_t predicted_outputs[$];
  parse_out_t want_beat;
  parse_out_t got_beat;

  int  items_sent = 0;
  int  beats_checked = 0;
  int  n_fail = 0;
  int  status_count [8];
  int  cycle_count = 0;
  bit  src_idle_en = 1'b0;
  bit  sink_idle_en = 1'b0;
  bit  hold_off_req = 1'b0;
  int  sink_stall_left = 0;

  command_frame_parser_top #(
    .MAX_PAYLOAD (MaxPayload),
    .MOTORS      (Motors)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d beats outstanding", $time, cycle_count,
               predicted_outputs.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shadow model of the parser
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    cfg_model  = DefaultCfg;
    hunt_st    = HUNT_HDR1;
    frame_kind = 8'h00;
    frame_len  = 8'h00;
    pay_count  = 0;
    run_xor    = 8'h00;
    fresh_flag = 1'b0;
    foreach (pay_store[i]) pay_store[i] = 8'h00;
    foreach (motor_tgt[i]) motor_tgt[i] = 16'sd0;
  endfunction

  // Acts on a frame whose checksum matched.
  function automatic logic [2:0] decode_frame();
    if (frame_kind == cfg_model.set_code && frame_len == TargetLen) begin
      for (int m = 0; m < TargetSlots; m++)
        motor_tgt[m] = (m < Motors) ? {pay_store[2*m+1], pay_store[2*m]} : 16'sd0;
      fresh_flag = 1'b1;
      return ST_SET;
    end
    if (frame_kind == cfg_model.stop_code && frame_len == 8'd0) begin
      foreach (motor_tgt[m]) motor_tgt[m] = 16'sd0;
      fresh_flag = 1'b1;
      return ST_STOPPED;
    end
    return ST_IGNORED;
  endfunction

  // Advances the frame hunt by one received byte.
  function automatic logic [2:0] hunt_byte(logic [7:0] b);
    logic [2:0] st;
    st = ST_NONE;
    case (hunt_st)
      HUNT_HDR1: if (b == cfg_model.first_hdr) hunt_st = HUNT_HDR2;
      HUNT_HDR2: hunt_st = (b == cfg_model.second_hdr) ? HUNT_TYPE : HUNT_HDR1;
      HUNT_TYPE: begin
        frame_kind = b;
        run_xor    = b;
        hunt_st    = HUNT_LEN;
      end
      HUNT_LEN: begin
        frame_len = b;
        run_xor   = run_xor ^ b;
        pay_count = 0;
        if (int'(b) > MaxPayload) begin
          hunt_st = HUNT_HDR1;
          st      = ST_TOO_LONG;
        end else if (b == 8'd0) begin
          hunt_st = HUNT_CHK;
        end else begin
          hunt_st = HUNT_PAY;
        end
      end
      HUNT_PAY: begin
        // Only the head of a long payload is stored; all of it is summed.
        if (pay_count < StoreDepth) pay_store[pay_count] = b;
        pay_count++;
        run_xor = run_xor ^ b;
        if (pay_count >= int'(frame_len)) hunt_st = HUNT_CHK;
      end
      HUNT_CHK: begin
        st      = (b == run_xor) ? decode_frame() : ST_BAD_SUM;
        hunt_st = HUNT_HDR1;
      end
      default: hunt_st = HUNT_HDR1;
    endcase
    return st;
  endfunction

  // Output beat expected for one accepted input beat.
  function automatic parse_out_t predict_parse(logic [1:0] act, logic [7:0] b);
    parse_out_t r;
    r.pad    = '0;
    r.fresh  = fresh_flag;
    r.status = ST_NONE;
    case (act)
      ACT_BYTE:   r.status = hunt_byte(b);
      ACT_RX_ERR: hunt_st = HUNT_HDR1;
      ACT_READ:   fresh_flag = 1'b0;
      default:    ;
    endcase
    r.tgt_a = motor_tgt[0];
    r.tgt_b = motor_tgt[1];
    r.tgt_c = motor_tgt[2];
    r.tgt_d = motor_tgt[3];
    status_count[r.status]++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: back-pressure and checking
  // ---------------------------------------------------------------------------

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (sink_stall_left > 0) begin
        sink_stall_left--;
        m_tready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req    = 1'b0;
        sink_stall_left = HoldOffCycles - 1;
        m_tready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 6) == 0) begin
        sink_stall_left = $urandom_range(0, 18);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      n_fail++;
      if (n_fail <= 40)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Compare every output beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_outputs.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected output beat, expected none, actual %h", $time, m_tdata);
      end else begin
        want_beat = predicted_outputs.pop_front();
        got_beat  = parse_out_t'(m_tdata);
        check_field("targets_fresh", 16'(want_beat.fresh), 16'(got_beat.fresh));
        check_field("target_a", want_beat.tgt_a, got_beat.tgt_a);
        check_field("target_b", want_beat.tgt_b, got_beat.tgt_b);
        check_field("target_c", want_beat.tgt_c, got_beat.tgt_c);
        check_field("target_d", want_beat.tgt_d, got_beat.tgt_d);
        check_field("frame_status", 16'(want_beat.status), 16'(got_beat.status));
        check_field("pad bits", 16'(want_beat.pad), 16'(got_beat.pad));
        beats_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one beat, waits for it to be taken, then records the prediction.
  task automatic send_beat(input logic [1:0] act, input logic [7:0] data);
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    predicted_outputs.push_back(predict_parse(act, data));
    items_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q, input int count);
    for (int i = 0; i < count && i < q.size(); i++) send_beat(ACT_BYTE, q[i]);
  endtask

  // Lets the block drain before touching the configuration.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input cfp_cfg_t c);
    logic [1:0] regs [4];
    logic [7:0] vals [4];
    regs = '{CFG_FIRST_HDR, CFG_SECOND_HDR, CFG_SET_CODE, CFG_STOP_CODE};
    vals = '{c.first_hdr, c.second_hdr, c.set_code, c.stop_code};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cfg_model = c;
  endtask

  // Header, type, length, payload and XOR checksum, optionally corrupted.
  function automatic byte_q_t build_frame(logic [7:0] kind, byte_q_t body, bit bad_sum);
    byte_q_t    q;
    logic [7:0] sum;
    sum = kind ^ 8'(body.size());
    q   = '{cfg_model.first_hdr, cfg_model.second_hdr, kind, 8'(body.size())};
    foreach (body[i]) begin
      q.push_back(body[i]);
      sum = sum ^ body[i];
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    q.push_back(sum);
    return q;
  endfunction

  function automatic byte_q_t random_body(int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // Eight-byte set-target payload, with the signed extremes mixed in.
  function automatic byte_q_t target_body();
    byte_q_t     q;
    logic [15:0] t;
    for (int m = 0; m < TargetSlots; m++) begin
      case ($urandom_range(0, 7))
        0:       t = 16'h7FFF;
        1:       t = 16'h8000;
        2:       t = 16'h0000;
        3:       t = 16'hFFFF;
        default: t = 16'($urandom_range(0, 65535));
      endcase
      q.push_back(t[7:0]);
      q.push_back(t[15:8]);
    end
    return q;
  endfunction

  // A length byte above the limit ends the frame right there.
  task automatic send_oversize(input logic [7:0] len);
    byte_q_t q;
    q = '{cfg_model.first_hdr, cfg_model.second_hdr, cfg_model.set_code, len};
    send_bytes(q, q.size());
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: each command, each outcome and the odd cases at least once.
  task automatic test_directed();
    byte_q_t q;
    byte_q_t none;
    q = build_frame(cfg_model.set_code,
                    '{8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h00, 8'h00}, 1'b0);
    send_bytes(q, q.size());
    send_beat(ACT_READ, 8'h00);
    send_beat(ACT_READ, 8'hFF);
    q = build_frame(cfg_model.stop_code, none, 1'b0);
    send_bytes(q, q.size());
    q = build_frame(cfg_model.stop_code, none, 1'b1);
    send_bytes(q, q.size());
    send_oversize(8'd33);
    send_oversize(8'hFF);
    send_beat(ACT_UNUSED, 8'hA5);
    // A receive error in the middle of a frame restarts the hunt.
    send_beat(ACT_BYTE, cfg_model.first_hdr);
    send_beat(ACT_BYTE, cfg_model.second_hdr);
    send_beat(ACT_RX_ERR, 8'h5A);
    // A repeated first header byte is not taken as a fresh start.
    send_beat(ACT_BYTE, cfg_model.first_hdr);
    q = build_frame(cfg_model.stop_code, none, 1'b0);
    send_bytes(q, q.size());
    // Good frames that decode to nothing.
    q = build_frame(cfg_model.set_code, none, 1'b0);
    send_bytes(q, q.size());
    q = build_frame(cfg_model.stop_code, '{8'h00}, 1'b0);
    send_bytes(q, q.size());
  endtask

  // Extreme and coinciding register values, each with a short frame mix.
  task automatic test_config_sweep();
    cfp_cfg_t settings [5];
    byte_q_t  q;
    byte_q_t  none;
    settings = '{'{8'h00, 8'hFF, 8'hFF, 8'h00},
                 '{8'hFF, 8'hFF, 8'h7E, 8'h7E},
                 '{8'h5A, 8'h00, 8'h80, 8'h01},
                 '{8'h55, 8'hAA, 8'h00, 8'hFF},
                 DefaultCfg};
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    foreach (settings[s]) begin
      apply_config(settings[s]);
      q = build_frame(cfg_model.set_code, target_body(), 1'b0);
      send_bytes(q, q.size());
      send_beat(ACT_READ, 8'($urandom_range(0, 255)));
      q = build_frame(cfg_model.stop_code, none, 1'b0);
      send_bytes(q, q.size());
      q = build_frame(8'($urandom_range(0, 255)), random_body(3), 1'b0);
      send_bytes(q, q.size());
      send_beat(ACT_BYTE, cfg_model.first_hdr);
      send_beat(ACT_BYTE, ~cfg_model.second_hdr);
      q = build_frame(cfg_model.set_code, target_body(), 1'b0);
      send_bytes(q, q.size());
    end
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames.
  task automatic test_random_traffic();
    int       phase_end;
    int       pick;
    byte_q_t  q;
    byte_q_t  none;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      apply_config(phase == 0 ? DefaultCfg : cfp_cfg_t'({pick_code(), pick_code(),
                                                         pick_code(), pick_code()}));
      phase_end = items_sent + RandomItems / 4;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        // Usually resync before a frame if noise left the hunt mid-frame.
        if (pick < 70 && hunt_st != HUNT_HDR1 && $urandom_range(0, 3) != 0)
          send_beat(ACT_RX_ERR, 8'($urandom_range(0, 255)));
        if (pick < 35) begin
          q = build_frame(cfg_model.set_code, target_body(), pick < 2);
          send_bytes(q, q.size());
        end else if (pick < 50) begin
          q = build_frame(cfg_model.stop_code, none, pick < 37);
          send_bytes(q, q.size());
        end else if (pick < 60) begin
          q = build_frame(8'($urandom_range(0, 255)),
                          random_body($urandom_range(0, MaxPayload)), pick < 52);
          send_bytes(q, q.size());
        end else if (pick < 65) begin
          send_oversize(8'($urandom_range(MaxPayload + 1, 255)));
        end else if (pick < 70) begin
          q = build_frame(pick[0] ? cfg_model.set_code : cfg_model.stop_code,
                          pick[0] ? target_body() : none, 1'b1);
          send_bytes(q, q.size());
        end else if (pick < 78) begin
          send_beat(ACT_READ, 8'($urandom_range(0, 255)));
        end else if (pick < 84) begin
          q = build_frame(cfg_model.set_code, target_body(), 1'b0);
          send_bytes(q, $urandom_range(1, q.size() - 1));
          if (pick[0]) send_beat(ACT_RX_ERR, 8'($urandom_range(0, 255)));
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 4)) send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
        end else if (pick < 94) begin
          send_beat(ACT_RX_ERR, 8'($urandom_range(0, 255)));
        end else if (pick < 97) begin
          send_beat(ACT_UNUSED, 8'($urandom_range(0, 255)));
        end else begin
          send_beat(ACT_BYTE, cfg_model.first_hdr);
          send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Receiver holds off for a long stretch while frames keep coming.
  task automatic test_output_stall();
    byte_q_t q;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_off_req = 1'b1;
    repeat (4) begin
      q = build_frame(cfg_model.set_code, target_body(), 1'b0);
      send_bytes(q, q.size());
      send_beat(ACT_READ, 8'($urandom_range(0, 255)));
    end
  endtask

  // Back-to-back beats with no idling on either side.
  task automatic test_full_rate();
    byte_q_t q;
    byte_q_t none;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (20) begin
      if ($urandom_range(0, 2) == 0)
        q = build_frame(cfg_model.stop_code, none, $urandom_range(0, 7) == 0);
      else
        q = build_frame(cfg_model.set_code, target_body(), $urandom_range(0, 7) == 0);
      send_bytes(q, q.size());
      send_beat(ACT_READ, 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    foreach (status_count[i]) status_count[i] = 0;
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_config_sweep();
    test_random_traffic();
    test_output_stall();
    test_full_rate();

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Checked %0d output beats for %0d input beats under several header/code settings.",
             beats_checked, items_sent);
    $display("Outcomes: %0d loads, %0d stops, %0d ignored, %0d bad checksums, %0d oversize.",
             status_count[ST_SET], status_count[ST_STOPPED], status_count[ST_IGNORED],
             status_count[ST_BAD_SUM], status_count[ST_TOO_LONG]);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
